// ===== hw/rtl/stick_radial_clamp_core_assert.svh =====
// assertion macros for the stick radial clamp core
// used by stick_radial_clamp_core.sv; expects clock and reset in the including scope
`ifndef STICK_RADIAL_CLAMP_CORE_ASSERT_SVH
`define STICK_RADIAL_CLAMP_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SRC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while in reset
`define SRC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/srclamp_pkg.sv =====
// shared types and constants for the stick radial clamp core
// no dependencies; used by every other .sv file of the block
`timescale 1ns / 1ps

package srclamp_pkg;

   // field types
   typedef logic signed [7:0]  coord_type;
   typedef logic signed [14:0] scaled_type;
   typedef logic [6:0]         radius_type;

   // internal arithmetic widths
   typedef logic [7:0]  mag_type;     // |coord|, up to 128
   typedef logic [15:0] sumsq_type;   // x*x + y*y, up to 32768
   typedef logic [13:0] rad_sq_type;  // radius squared
   typedef logic [13:0] prod_type;    // radius * |coord|, up to 16256
   typedef logic [29:0] wide_type;    // limit and trial products
   typedef logic [6:0]  quo_type;     // clamped magnitude
   typedef logic [13:0] qsq_type;     // clamped magnitude squared

   localparam int         RADIUS_RESET_N  = 80;
   localparam radius_type RADIUS_RESET    = radius_type'(RADIUS_RESET_N);
   localparam rad_sq_type RADIUS_SQ_RESET = rad_sq_type'(RADIUS_RESET_N * RADIUS_RESET_N);
   localparam scaled_type SCALE_FACTOR    = 15'sd125;
   localparam coord_type  COORD_MIN       = 8'sh80;

   // one result bit per solve stage of the back end
   localparam int QBITS  = $bits(quo_type);
   localparam int STEP_W = $clog2(QBITS);
   typedef logic [STEP_W-1:0] step_type;

   // four coordinate lanes: main x, main y, sub x, sub y
   localparam int NLANES = 4;

   // queue between front and back
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_DEPTH = 1 << QUEUE_AW;
   typedef logic [QUEUE_AW-1:0] qptr_type;
   typedef logic [QUEUE_AW:0]   qcnt_type;

   // classified stick, as produced by the front end
   typedef struct packed {
      coord_type x;
      coord_type y;
      sumsq_type s;
      prod_type  rax;
      prod_type  ray;
      logic      clamp;
   } stick_class_type;

   typedef struct packed {
      stick_class_type main_s;
      stick_class_type sub_s;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== hw/rtl/srclamp_ifs.sv =====
// valid/ready channel interfaces for sample transactions and result transactions
// depends on srclamp_pkg
`timescale 1ns / 1ps

interface srclamp_req_if;
   import srclamp_pkg::*;

   logic      valid;
   logic      ready;
   coord_type main_x;
   coord_type main_y;
   coord_type sub_x;
   coord_type sub_y;

   modport source (output valid, main_x, main_y, sub_x, sub_y, input ready);
   modport sink   (input valid, main_x, main_y, sub_x, sub_y, output ready);
endinterface

interface srclamp_rsp_if;
   import srclamp_pkg::*;

   logic       valid;
   logic       ready;
   coord_type  main_x_clamped;
   coord_type  main_y_clamped;
   coord_type  sub_x_clamped;
   coord_type  sub_y_clamped;
   scaled_type main_x_scaled;
   scaled_type main_y_scaled;
   scaled_type sub_x_scaled;
   scaled_type sub_y_scaled;

   modport source (output valid, main_x_clamped, main_y_clamped, sub_x_clamped,
                   sub_y_clamped, main_x_scaled, main_y_scaled, sub_x_scaled,
                   sub_y_scaled, input ready);
   modport sink   (input valid, main_x_clamped, main_y_clamped, sub_x_clamped,
                   sub_y_clamped, main_x_scaled, main_y_scaled, sub_x_scaled,
                   sub_y_scaled, output ready);
endinterface

// ===== hw/rtl/srclamp_front.sv =====
// front end: radius register, sample acceptance and per-stick classification
// depends on srclamp_pkg and srclamp_ifs
`timescale 1ns / 1ps

module srclamp_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  srclamp_pkg::radius_type       csr_wr_data,
   srclamp_req_if.sink                   req_ch,
   input  srclamp_pkg::queue_status_type q_status,
   output logic                          push_valid,
   output srclamp_pkg::entry_type        push_entry
);
   import srclamp_pkg::*;

   radius_type radius_ff;
   rad_sq_type radius_sq_ff;
   logic       front_valid_ff, front_valid_in;
   entry_type  front_entry_ff, front_entry_in;
   logic       accept;
   logic       pushed;

   // squared length, clamp decision and radius products for one stick
   function automatic stick_class_type classify(coord_type x, coord_type y,
                                                radius_type r, rad_sq_type rsq);
      mag_type         ax;
      mag_type         ay;
      stick_class_type c;
      ax      = x[7] ? mag_type'(-x) : mag_type'(x);
      ay      = y[7] ? mag_type'(-y) : mag_type'(y);
      c.x     = x;
      c.y     = y;
      c.s     = sumsq_type'(ax) * sumsq_type'(ax) + sumsq_type'(ay) * sumsq_type'(ay);
      c.clamp = c.s > sumsq_type'(rsq);
      c.rax   = prod_type'(r) * prod_type'(ax);
      c.ray   = prod_type'(r) * prod_type'(ay);
      return c;
   endfunction

   // radius register and its square
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= RADIUS_RESET;
         radius_sq_ff <= RADIUS_SQ_RESET;
      end else if (csr_wr_en) begin
         radius_ff    <= csr_wr_data;
         radius_sq_ff <= rad_sq_type'(csr_wr_data) * rad_sq_type'(csr_wr_data);
      end
   end

   // input handshake: take a transaction whenever the holding register frees up
   assign pushed       = front_valid_ff && !q_status.full;
   assign req_ch.ready = !front_valid_ff || !q_status.full;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      front_valid_in        = accept || (front_valid_ff && !pushed);
      front_entry_in        = front_entry_ff;
      if (accept) begin
         front_entry_in.main_s = classify(req_ch.main_x, req_ch.main_y, radius_ff,
                                          radius_sq_ff);
         front_entry_in.sub_s  = classify(req_ch.sub_x, req_ch.sub_y, radius_ff,
                                          radius_sq_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_entry_ff <= front_entry_in;
   end

   assign push_valid = front_valid_ff;
   assign push_entry = front_entry_ff;

endmodule

// ===== hw/rtl/srclamp_queue.sv =====
// short fifo of classified samples between front end and back end
// depends on srclamp_pkg
`timescale 1ns / 1ps

module srclamp_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_valid,
   input  srclamp_pkg::entry_type        push_entry,
   input  logic                          pop_en,
   output srclamp_pkg::entry_type        pop_entry,
   output srclamp_pkg::queue_status_type q_status
);
   import srclamp_pkg::*;

   entry_type slot_ff [QUEUE_DEPTH];
   qptr_type  wr_ptr_ff, wr_ptr_in;
   qptr_type  rd_ptr_ff, rd_ptr_in;
   qcnt_type  count_ff, count_in;
   logic      do_push;
   logic      do_pop;

   assign q_status.full  = count_ff == qcnt_type'(QUEUE_DEPTH);
   assign q_status.empty = count_ff == '0;
   assign do_push        = push_valid && !q_status.full;
   assign do_pop         = pop_en && !q_status.empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_entry = slot_ff[rd_ptr_ff];

endmodule

// ===== hw/rtl/srclamp_back.sv =====
// back end: bit-per-stage solve of the clamped magnitude, sign restore, scaling
// depends on srclamp_pkg and srclamp_ifs
`timescale 1ns / 1ps

module srclamp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  srclamp_pkg::queue_status_type q_status,
   input  srclamp_pkg::entry_type        pop_entry,
   output logic                          pop_en,
   srclamp_rsp_if.source                 rsp_ch
);
   import srclamp_pkg::*;

   typedef struct packed {
      coord_type orig;
      logic      clamp;
      sumsq_type s;
      wide_type  lim;
      quo_type   q;
      qsq_type   qsq;
   } lane_type;

   lane_type        lane_ff [QBITS+1][NLANES];
   lane_type        lane_in [QBITS+1][NLANES];
   logic [QBITS:0]  vld_ff, vld_in;
   logic            out_valid_ff, out_valid_in;
   coord_type       clamped_ff [NLANES];
   coord_type       clamped_in [NLANES];
   scaled_type      scaled_ff [NLANES];
   scaled_type      scaled_in [NLANES];
   logic            advance;

   // first stage: limit = (radius * |coord|)^2, solve state cleared
   function automatic lane_type load_lane(coord_type c, sumsq_type s, prod_type rc,
                                          logic clamp);
      lane_type l;
      l.orig  = c;
      l.clamp = clamp;
      l.s     = s;
      l.lim   = wide_type'(rc) * wide_type'(rc);
      l.q     = '0;
      l.qsq   = '0;
      return l;
   endfunction

   // one result bit: keep it if (q | bit)^2 * s stays within the limit
   function automatic lane_type solve_step(lane_type l, step_type k);
      quo_type  trial;
      qsq_type  tsq;
      wide_type test;
      lane_type n;
      n     = l;
      trial = l.q | (quo_type'(1) << k);
      tsq   = l.qsq + (qsq_type'(l.q) << (k + 1)) + (qsq_type'(1) << (2 * k));
      test  = wide_type'(tsq) * wide_type'(l.s);
      if (test <= l.lim) begin
         n.q   = trial;
         n.qsq = tsq;
      end
      return n;
   endfunction

   // whole pipe moves when the output register is free or being drained
   assign advance = !out_valid_ff || rsp_ch.ready;
   assign pop_en  = advance;

   // stage data
   always_comb begin
      lane_in[0][0] = load_lane(pop_entry.main_s.x, pop_entry.main_s.s,
                                pop_entry.main_s.rax, pop_entry.main_s.clamp);
      lane_in[0][1] = load_lane(pop_entry.main_s.y, pop_entry.main_s.s,
                                pop_entry.main_s.ray, pop_entry.main_s.clamp);
      lane_in[0][2] = load_lane(pop_entry.sub_s.x, pop_entry.sub_s.s,
                                pop_entry.sub_s.rax, pop_entry.sub_s.clamp);
      lane_in[0][3] = load_lane(pop_entry.sub_s.y, pop_entry.sub_s.s,
                                pop_entry.sub_s.ray, pop_entry.sub_s.clamp);
      for (int st = 1; st <= QBITS; st++) begin
         for (int ln = 0; ln < NLANES; ln++) begin
            lane_in[st][ln] = solve_step(lane_ff[st-1][ln], step_type'(QBITS - st));
         end
      end
   end

   // sign restore and times-125 into the output register
   always_comb begin
      for (int ln = 0; ln < NLANES; ln++) begin
         clamped_in[ln] = lane_ff[QBITS][ln].orig;
         if (lane_ff[QBITS][ln].clamp) begin
            clamped_in[ln] = lane_ff[QBITS][ln].orig[7] ?
                             -coord_type'({1'b0, lane_ff[QBITS][ln].q}) :
                             coord_type'({1'b0, lane_ff[QBITS][ln].q});
         end
         scaled_in[ln] = scaled_type'(clamped_in[ln]) * SCALE_FACTOR;
      end
   end

   // stage valid bits
   assign vld_in       = {vld_ff[QBITS-1:0], !q_status.empty};
   assign out_valid_in = vld_ff[QBITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= vld_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lane_ff    <= lane_in;
         clamped_ff <= clamped_in;
         scaled_ff  <= scaled_in;
      end
   end

   // result transaction
   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.main_x_clamped = clamped_ff[0];
   assign rsp_ch.main_y_clamped = clamped_ff[1];
   assign rsp_ch.sub_x_clamped  = clamped_ff[2];
   assign rsp_ch.sub_y_clamped  = clamped_ff[3];
   assign rsp_ch.main_x_scaled  = scaled_ff[0];
   assign rsp_ch.main_y_scaled  = scaled_ff[1];
   assign rsp_ch.sub_x_scaled   = scaled_ff[2];
   assign rsp_ch.sub_y_scaled   = scaled_ff[3];

endmodule

// ===== hw/rtl/stick_radial_clamp_core.sv =====
// stick_radial_clamp_core: radial clamp of a main stick and a C-stick sample. Each stick
// whose length exceeds csr_wr_data's radius (reset 80) is scaled onto that circle, truncated
// toward zero, and each clamped coordinate is also given times 125. A new sample transaction
// is taken every cycle unless the front register holds an entry and the four-entry queue is
// full; each sample passes through classification, the queue, the limit product, seven
// solve stages (one result bit each, one multiply per stage) and the output register.
// Depends on srclamp_pkg, srclamp_ifs, srclamp_front, srclamp_queue, srclamp_back and
// stick_radial_clamp_core_assert.svh.
`timescale 1ns / 1ps

module stick_radial_clamp_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  srclamp_pkg::radius_type csr_wr_data,
   srclamp_req_if.sink             req_ch,
   srclamp_rsp_if.source           rsp_ch
);
   import srclamp_pkg::*;

   `include "stick_radial_clamp_core_assert.svh"

   queue_status_type q_status;
   logic             push_valid;
   entry_type        push_entry;
   logic             pop_en;
   entry_type        pop_entry;

   // accept and classify
   srclamp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .q_status    (q_status),
      .push_valid  (push_valid),
      .push_entry  (push_entry)
   );

   // decoupling queue
   srclamp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop_en     (pop_en),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   // solve and deliver
   srclamp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .pop_entry (pop_entry),
      .pop_en    (pop_en),
      .rsp_ch    (rsp_ch)
   );

   // checks
   `SRC_ASSERT_NEXT(a_accept_fills_front, req_ch.valid && req_ch.ready, push_valid, "accepted transaction lost before the queue")
   `SRC_ASSERT_NEXT(a_front_holds_on_full, push_valid && q_status.full, push_valid && $stable(push_entry), "front entry changed while queue full")
   `SRC_ASSERT_IMP(a_clamped_in_range, rsp_ch.valid, (rsp_ch.main_x_clamped != COORD_MIN) && (rsp_ch.sub_y_clamped != COORD_MIN), "clamped coordinate out of range")

endmodule
